### rtl/core/bli_pkg.sv
package bli_pkg;

    localparam int IDX_W   = 4;
    localparam int MAX_BP  = 1 << IDX_W;
    localparam int CNT_W   = 5;
    localparam int TEMP_W  = 16;
    localparam int QT_W    = 12;
    localparam int PROP_W  = 24;
    localparam int FRAC_W  = 16;
    localparam int NPROP   = 3;
    localparam int K_W     = $clog2(NPROP);
    localparam int DCNT_W  = $clog2(FRAC_W);
    localparam int PROD_W  = FRAC_W + PROP_W;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [NPROP-1:0][PROP_W-1:0] prop_vec_t;

    typedef struct packed {
        logic              command;
        logic [IDX_W-1:0]  entry_index;
        logic [TEMP_W-1:0] breakpoint_temperature;
        logic [PROP_W-1:0] conductivity_point;
        logic [PROP_W-1:0] heat_capacity_point;
        logic [PROP_W-1:0] density_point;
        logic [QT_W-1:0]   query_temperature;
    } item_t;

    typedef struct packed {
        logic [PROP_W-1:0] conductivity_out;
        logic [PROP_W-1:0] heat_capacity_out;
        logic [PROP_W-1:0] density_out;
        logic              order_error;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [TEMP_W-1:0] temp;
        prop_vec_t         props;
    } tbl_wr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_CHK0,
        S_CHK_LAST,
        S_SCAN,
        S_DIV,
        S_PLO,
        S_PHI,
        S_LERP,
        S_FETCH,
        S_PUT
    } state_t;

endpackage

### rtl/core/breakpoint_linear_interpolator.sv
// Breakpoint linear interpolator: a table of up to 16 breakpoints, each a
// Q12.4 temperature with conductivity, specific heat and density in Q16.8.
// Command channel: an item is taken at a clock edge with start high and busy
// low. A load writes one entry at entry_index and gives no result; busy stays
// low, so loads may follow every cycle. A query takes an integer temperature
// and gives one result beat on result, marked by done for exactly one cycle;
// the receiver has no way to stall it.
// Query paths: the temperature is clamped to the first or to the last entry,
// or the scan ends at a segment without a hit, or it interpolates in the
// segment that it hits: the scan reads one breakpoint per cycle from the
// table memory, the fraction comes from a bit-serial divider and the three
// properties share one multiplier.
// busy falls with done, so the next item may start in the cycle done is high.
// Config channel: cfg_data sets breakpoint_count at an edge with cfg_valid and
// cfg_ready high; it is meant to change only between queries.
// Reset sets breakpoint_count to 2 and aborts any query; table contents are
// not cleared and must be loaded before use.
module breakpoint_linear_interpolator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bli_pkg::item_t              item,
    output logic                        done,
    output bli_pkg::result_t            result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bli_pkg::CNT_W-1:0]   cfg_data
);
    import bli_pkg::*;

    state_t             state_reg;
    state_t             state_next;

    logic [CNT_W-1:0]   count_reg;
    logic [TEMP_W-1:0]  q_reg;
    logic [IDX_W-1:0]   last_reg;
    logic [TEMP_W-1:0]  prev_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   seg_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               err_reg;
    prop_vec_t          lo_reg;
    result_t            result_reg;
    logic               done_reg;

    tbl_wr_t            tbl_wr;
    logic [IDX_W-1:0]   tmp_addr;
    logic [TEMP_W-1:0]  tmp_data;
    logic [IDX_W-1:0]   prop_addr;
    prop_vec_t          prop_data;

    logic               div_start;
    logic               div_done;
    logic [FRAC_W-1:0]  frac;
    logic               lerp_start;
    logic               lerp_done;
    prop_vec_t          lerp_res;

    logic               accept;
    logic [CNT_W-1:0]   count_m1;
    logic [IDX_W-1:0]   last_calc;
    logic               q_le_first;
    logic               q_ge_last;
    logic               seg_hit;
    logic [IDX_W-1:0]   i_plus1;
    logic               scan_end;

    always_comb
    begin
        accept     = start && (state_reg == S_IDLE);
        count_m1   = count_reg - CNT_W'(1);
        if (count_reg == '0)
        begin
            last_calc = '0;
        end
        else if (count_reg > CNT_W'(MAX_BP))
        begin
            last_calc = IDX_W'(MAX_BP - 1);
        end
        else
        begin
            last_calc = count_m1[IDX_W-1:0];
        end
        q_le_first = q_reg <= tmp_data;
        q_ge_last  = q_reg >= tmp_data;
        seg_hit    = (prev_reg <= q_reg) && (q_reg < tmp_data);
        i_plus1    = i_reg + IDX_W'(1);
        scan_end   = i_plus1 == last_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && item.command == CMD_QUERY)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                state_next = S_CHK0;
            end
            S_CHK0:
            begin
                state_next = q_le_first ? S_FETCH : S_CHK_LAST;
            end
            S_CHK_LAST:
            begin
                state_next = q_ge_last ? S_FETCH : S_SCAN;
            end
            S_SCAN:
            begin
                if (seg_hit)
                begin
                    state_next = S_DIV;
                end
                else if (scan_end)
                begin
                    state_next = S_FETCH;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_PLO;
                end
            end
            S_PLO:
            begin
                state_next = S_PHI;
            end
            S_PHI:
            begin
                state_next = S_LERP;
            end
            S_LERP:
            begin
                if (lerp_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                state_next = S_PUT;
            end
            S_PUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy       = state_reg != S_IDLE;
        cfg_ready  = state_reg == S_IDLE;
        div_start  = 1'b0;
        lerp_start = 1'b0;
        tmp_addr   = '0;
        prop_addr  = seg_reg;

        tbl_wr.en    = accept && item.command == CMD_LOAD;
        tbl_wr.idx   = item.entry_index;
        tbl_wr.temp  = item.breakpoint_temperature;
        tbl_wr.props = {item.density_point, item.heat_capacity_point,
                        item.conductivity_point};

        unique case (state_reg)
            S_RD0:
            begin
                tmp_addr = '0;
            end
            S_CHK0:
            begin
                tmp_addr = last_reg;
            end
            S_CHK_LAST:
            begin
                tmp_addr = IDX_W'(1);
            end
            S_SCAN:
            begin
                // prefetch the breakpoint after the one being compared
                tmp_addr  = i_reg + IDX_W'(2);
                div_start = seg_hit;
            end
            S_DIV:
            begin
                prop_addr = seg_reg;
            end
            S_PLO:
            begin
                prop_addr = seg_reg + IDX_W'(1);
            end
            S_PHI:
            begin
                lerp_start = 1'b1;
            end
            S_FETCH:
            begin
                prop_addr = out_idx_reg;
            end
            default:
            begin
                tmp_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= COUNT_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            done_reg <= (state_reg == S_PUT) || (state_reg == S_LERP && lerp_done);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    q_reg    <= {item.query_temperature, 4'b0000};
                    last_reg <= last_calc;
                end
            end
            S_CHK0:
            begin
                prev_reg    <= tmp_data;
                out_idx_reg <= '0;
                err_reg     <= 1'b0;
            end
            S_CHK_LAST:
            begin
                out_idx_reg <= last_reg;
                err_reg     <= 1'b0;
                i_reg       <= '0;
            end
            S_SCAN:
            begin
                seg_reg     <= i_reg;
                out_idx_reg <= last_reg;
                err_reg     <= 1'b1;
                if (!seg_hit)
                begin
                    prev_reg <= tmp_data;
                    i_reg    <= i_plus1;
                end
            end
            S_PLO:
            begin
                lo_reg <= prop_data;
            end
            S_LERP:
            begin
                if (lerp_done)
                begin
                    result_reg.conductivity_out  <= lerp_res[0];
                    result_reg.heat_capacity_out <= lerp_res[1];
                    result_reg.density_out       <= lerp_res[2];
                    result_reg.order_error       <= 1'b0;
                end
            end
            S_PUT:
            begin
                result_reg.conductivity_out  <= prop_data[0];
                result_reg.heat_capacity_out <= prop_data[1];
                result_reg.density_out       <= prop_data[2];
                result_reg.order_error       <= err_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    bli_table u_table (
        .clk       (clk),
        .wr        (tbl_wr),
        .tmp_addr  (tmp_addr),
        .tmp_data  (tmp_data),
        .prop_addr (prop_addr),
        .prop_data (prop_data)
    );

    bli_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (q_reg - prev_reg),
        .den   (tmp_data - prev_reg),
        .done  (div_done),
        .quot  (frac)
    );

    bli_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lerp_start),
        .frac  (frac),
        .lo    (lo_reg),
        .hi    (prop_data),
        .done  (lerp_done),
        .res   (lerp_res)
    );

endmodule

### rtl/core/bli_table.sv
module bli_table (
    input  logic                        clk,
    input  bli_pkg::tbl_wr_t            wr,
    input  logic [bli_pkg::IDX_W-1:0]   tmp_addr,
    output logic [bli_pkg::TEMP_W-1:0]  tmp_data,
    input  logic [bli_pkg::IDX_W-1:0]   prop_addr,
    output bli_pkg::prop_vec_t          prop_data
);
    import bli_pkg::*;

    logic [TEMP_W-1:0] tmp_mem  [MAX_BP];
    prop_vec_t         prop_mem [MAX_BP];

    // breakpoint temperatures
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tmp_mem[wr.idx] <= wr.temp;
        end
        tmp_data <= tmp_mem[tmp_addr];
    end

    // property values
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            prop_mem[wr.idx] <= wr.props;
        end
        prop_data <= prop_mem[prop_addr];
    end

endmodule

### rtl/core/bli_divider.sv
module bli_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bli_pkg::TEMP_W-1:0]  num,
    input  logic [bli_pkg::TEMP_W-1:0]  den,
    output logic                        done,
    output logic [bli_pkg::FRAC_W-1:0]  quot
);
    import bli_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic [TEMP_W-1:0]  rem_reg;
    logic [TEMP_W-1:0]  den_reg;
    logic [FRAC_W-1:0]  quot_reg;

    logic [TEMP_W:0]    shifted;
    logic               ge;
    logic [TEMP_W:0]    diff;

    // one quotient bit per cycle, remainder stays below the divisor
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        ge      = shifted >= {1'b0, den_reg};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(FRAC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[TEMP_W-1:0] : shifted[TEMP_W-1:0];
            quot_reg <= {quot_reg[FRAC_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### rtl/core/bli_lerp.sv
module bli_lerp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bli_pkg::FRAC_W-1:0]  frac,
    input  bli_pkg::prop_vec_t          lo,
    input  bli_pkg::prop_vec_t          hi,
    output logic                        done,
    output bli_pkg::prop_vec_t          res
);
    import bli_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic               phase_reg;
    logic [K_W-1:0]     k_reg;
    logic [FRAC_W-1:0]  frac_reg;
    prop_vec_t          lo_reg;
    prop_vec_t          hi_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               down_reg;
    logic [PROP_W-1:0]  base_reg;
    prop_vec_t          res_reg;

    logic [PROP_W-1:0]  lo_k;
    logic [PROP_W-1:0]  hi_k;
    logic               down;
    logic [PROP_W-1:0]  mag;
    logic [PROD_W-1:0]  prod_up;
    logic [PROP_W-1:0]  value;

    always_comb
    begin
        lo_k    = lo_reg[k_reg];
        hi_k    = hi_reg[k_reg];
        down    = hi_k < lo_k;
        mag     = down ? (lo_k - hi_k) : (hi_k - lo_k);
        // rounding up the step keeps a falling slope floored
        prod_up = prod_reg + PROD_W'((1 << FRAC_W) - 1);
        if (down_reg)
        begin
            value = base_reg - prod_up[PROD_W-1:FRAC_W];
        end
        else
        begin
            value = base_reg + prod_reg[PROD_W-1:FRAC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                k_reg     <= '0;
            end
            else if (busy_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    if (k_reg == K_W'(NPROP - 1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg <= k_reg + K_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            frac_reg <= frac;
            lo_reg   <= lo;
            hi_reg   <= hi;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                prod_reg <= PROD_W'(frac_reg) * PROD_W'(mag);
                down_reg <= down;
                base_reg <= lo_k;
            end
            else
            begin
                res_reg[k_reg] <= value;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import bli_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [PROP_W-1:0] PROP_MAX = {PROP_W{1'b1}};

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    item_t item_in = '0;
    logic done;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    logic [TEMP_W-1:0] temp_table [MAX_BP];
    logic [PROP_W-1:0] cond_table [MAX_BP];
    logic [PROP_W-1:0] heat_table [MAX_BP];
    logic [PROP_W-1:0] dens_table [MAX_BP];
    logic [CNT_W-1:0] count_reg = COUNT_RESET;

    result_t pending_props [$];
    result_t want_r;
    int error_count = 0;
    int cycle_count = 0;
    bit steady = 1'b0;

    breakpoint_linear_interpolator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item_in),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("breakpoint_linear_interpolator: mismatch");
            $finish;
        end
    end

    function automatic logic [PROP_W-1:0] blend_property(logic [PROP_W-1:0] lo,
                                                          logic [PROP_W-1:0] hi,
                                                          logic [FRAC_W-1:0] frac);
        logic [PROD_W-1:0] prod;
        if (hi >= lo)
        begin
            prod = frac * (hi - lo);
            return lo + prod[PROD_W-1:FRAC_W];
        end
        prod = frac * (lo - hi);
        return lo - PROP_W'((prod + PROD_W'(65535)) >> FRAC_W);
    endfunction

    function automatic result_t entry_result(int idx, logic err);
        result_t r;
        r.conductivity_out = cond_table[idx];
        r.heat_capacity_out = heat_table[idx];
        r.density_out = dens_table[idx];
        r.order_error = err;
        return r;
    endfunction

    function automatic result_t interpolate_expected(logic [QT_W-1:0] q_deg);
        result_t r;
        int n;
        int last;
        logic [TEMP_W-1:0] q16;
        logic [31:0] quot;
        logic [FRAC_W-1:0] frac;
        bit found;
        n = (count_reg == 0) ? 1 : (count_reg > MAX_BP) ? MAX_BP : int'(count_reg);
        last = n - 1;
        q16 = {q_deg, 4'h0};
        found = 1'b0;
        if (q16 <= temp_table[0])
            return entry_result(0, 1'b0);
        if (q16 >= temp_table[last])
            return entry_result(last, 1'b0);
        for (int i = 0; i + 1 < n; i++)
        begin
            if (!found && temp_table[i] <= q16 && q16 < temp_table[i+1])
            begin
                quot = {q16 - temp_table[i], 16'h0000} / (temp_table[i+1] - temp_table[i]);
                frac = quot[FRAC_W-1:0];
                r.conductivity_out = blend_property(cond_table[i], cond_table[i+1], frac);
                r.heat_capacity_out = blend_property(heat_table[i], heat_table[i+1], frac);
                r.density_out = blend_property(dens_table[i], dens_table[i+1], frac);
                r.order_error = 1'b0;
                found = 1'b1;
            end
        end
        if (!found)
            r = entry_result(last, 1'b1);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [PROP_W-1:0] want,
                               input logic [PROP_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_props.size() == 0)
            begin
                error_count++;
                $display("%0t: result expected none actual %h", $time, result);
            end
            else
            begin
                want_r = pending_props.pop_front();
                check_field("conductivity", want_r.conductivity_out, result.conductivity_out);
                check_field("heat_capacity", want_r.heat_capacity_out,
                            result.heat_capacity_out);
                check_field("density", want_r.density_out, result.density_out);
                check_field("order_error", PROP_W'(want_r.order_error),
                            PROP_W'(result.order_error));
            end
        end
    end

    function automatic logic [PROP_W-1:0] pick_property();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PROP_MAX;
            default: return PROP_W'($urandom);
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.command = 1'($urandom);
        it.entry_index = IDX_W'($urandom);
        it.breakpoint_temperature = TEMP_W'($urandom);
        it.conductivity_point = PROP_W'($urandom);
        it.heat_capacity_point = PROP_W'($urandom);
        it.density_point = PROP_W'($urandom);
        it.query_temperature = QT_W'($urandom);
        return it;
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item_in <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (it.command == CMD_QUERY)
            pending_props = {pending_props, interpolate_expected(it.query_temperature)};
        else
        begin
            temp_table[it.entry_index] = it.breakpoint_temperature;
            cond_table[it.entry_index] = it.conductivity_point;
            heat_table[it.entry_index] = it.heat_capacity_point;
            dens_table[it.entry_index] = it.density_point;
        end
    endtask

    task automatic load_entry(input int idx, input logic [TEMP_W-1:0] temp,
                              input logic [PROP_W-1:0] c, input logic [PROP_W-1:0] h,
                              input logic [PROP_W-1:0] d);
        item_t it;
        it = random_item();
        it.command = CMD_LOAD;
        it.entry_index = IDX_W'(idx);
        it.breakpoint_temperature = temp;
        it.conductivity_point = c;
        it.heat_capacity_point = h;
        it.density_point = d;
        send_item(it);
    endtask

    task automatic query_at(input int q);
        item_t it;
        it = random_item();
        it.command = CMD_QUERY;
        it.query_temperature = QT_W'(q);
        send_item(it);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_props.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= CNT_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        count_reg = CNT_W'(value);
    endtask

    task automatic load_directed_table();
        for (int i = 0; i < MAX_BP; i++)
            load_entry(i, (i == MAX_BP - 1) ? 16'hFFFF : TEMP_W'(16 + i * 4000),
                       i[0] ? PROP_MAX : '0, PROP_W'(i * 1000000),
                       PROP_MAX - PROP_W'(i * 1000000));
    endtask

    task automatic load_random_table(input int kind);
        int t;
        t = (kind == 1) ? $urandom_range(0, 60000) : $urandom_range(0, 2000);
        if ($urandom_range(0, 3) == 0)
            t = 0;
        for (int i = 0; i < MAX_BP; i++)
        begin
            if (kind == 2)
                t = $urandom_range(0, 65535);
            else if (i > 0)
                t = t + ((kind == 1) ? $urandom_range(1, 64) :
                         (kind == 3) ? $urandom_range(0, 3000) : $urandom_range(1, 4000));
            if (t > 65535)
                t = 65535;
            load_entry(i, TEMP_W'(t), pick_property(), pick_property(), pick_property());
        end
    endtask

    task automatic test_reset_count();
        load_directed_table();
        query_at(0);
        query_at(4095);
        query_at(200);
    endtask

    task automatic test_clamp_and_exact();
        write_count(16);
        query_at(0);
        query_at(1);
        query_at(250);
        query_at(751);
        query_at(3501);
        query_at(4095);
    endtask

    task automatic test_count_limits();
        write_count(0);
        query_at(0);
        query_at(2000);
        write_count(1);
        query_at(4095);
        write_count(31);
        query_at(3000);
        query_at(4095);
        write_count(15);
        query_at(4095);
        query_at(3501);
    endtask

    task automatic test_unordered_table();
        load_entry(3, 16'hFFFF, PROP_MAX, '0, PROP_MAX);
        load_entry(4, 16'h0000, '0, PROP_MAX, '0);
        load_entry(6, TEMP_W'(16 + 5 * 4000), pick_property(), pick_property(),
                   pick_property());
        write_count(8);
        query_at(300);
        query_at(1000);
        query_at(2000);
        write_count(5);
        query_at(0);
        query_at(100);
    endtask

    task automatic test_random();
        int kind;
        int n;
        int lo_q;
        int hi_q;
        item_t it;
        for (int ph = 0; ph < 10; ph++)
        begin
            kind = $urandom_range(0, 3);
            steady = ($urandom_range(0, 3) == 0);
            load_random_table(kind);
            write_count(($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) :
                        $urandom_range(2, 16));
            n = (count_reg == 0) ? 1 : (count_reg > MAX_BP) ? MAX_BP : int'(count_reg);
            for (int k = 0; k < 64; k++)
            begin
                if (k == 32 && (ph == 0 || $urandom_range(0, 1) == 1))
                    wait_idle();
                it = random_item();
                if ($urandom_range(0, 99) < 15)
                begin
                    it.command = CMD_LOAD;
                    if (kind != 2 && $urandom_range(0, 3) > 0)
                        it.breakpoint_temperature = temp_table[it.entry_index];
                end
                else
                begin
                    it.command = CMD_QUERY;
                    lo_q = temp_table[0] >> 4;
                    hi_q = (temp_table[n-1] >> 4) + 1;
                    if (hi_q > 4095)
                        hi_q = 4095;
                    if ($urandom_range(0, 9) > 0)
                        it.query_temperature = QT_W'($urandom_range(lo_q, hi_q));
                end
                send_item(it);
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_count();
        test_clamp_and_exact();
        test_count_limits();
        test_unordered_table();
        test_random();
        wait_idle();
        if (error_count == 0 && pending_props.size() == 0)
            $display("breakpoint_linear_interpolator: match");
        else
            $display("breakpoint_linear_interpolator: mismatch");
        $finish;
    end

endmodule
